// File: design/dsfp_pkg.sv
// Package for the dual-sensor flow pulse counter.
// Holds the item and result structs, the fault codes and the fixed constants.
// Depends on nothing; every module of the block imports it.
package dsfp_pkg;

   typedef enum logic [1:0] {
      FAULT_NORMAL = 2'd0,
      FAULT_ONE    = 2'd1,
      FAULT_TWO    = 2'd2,
      FAULT_IFR    = 2'd3
   } fault_code_type;

   typedef enum logic {
      CMD_SENSOR_ONE = 1'b0,
      CMD_SENSOR_TWO = 1'b1
   } command_type;

   typedef struct packed {
      command_type command;
      logic        pin_low;
      logic [1:0]  interfere_pins;
      logic        uplink_busy;
   } event_type;

   typedef struct packed {
      logic [31:0]    flow_count;
      fault_code_type fault_code;
      logic           alarm_request;
   } result_type;

   localparam logic [7:0] LOSS_LIMIT_RESET = 8'd10;
   localparam logic [7:0] LOSS_COUNT_MAX   = 8'hFF;
   localparam logic [1:0] INTERFERE_MASK   = 2'h3;

   // Bit positions of the sticky reported marks.
   localparam int unsigned MARK_ONE = 0;
   localparam int unsigned MARK_TWO = 1;
   localparam int unsigned MARK_IFR = 2;

endpackage

// File: design/dsfp_in_reg.sv
// Input register of the dual-sensor flow pulse counter.
// Captures one event item and holds it until the processing stage takes it.
// Depends on dsfp_pkg.
module dsfp_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  dsfp_pkg::event_type in_item,
   output logic                in_stall,
   input  logic                advance,
   output logic                held_valid,
   output dsfp_pkg::event_type held_item
);
   import dsfp_pkg::*;

   logic      valid_ff, valid_in;
   event_type item_ff, item_in;
   logic      load;

   // The register may take a new item when it is empty or its item leaves now.
   assign load     = !valid_ff || advance;
   assign in_stall = !load;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// File: design/dsfp_core.sv
// State and update logic of the dual-sensor flow pulse counter.
// Holds the phase, flow total, loss counters, fault code, sticky marks and loss limit.
// Depends on dsfp_pkg.
module dsfp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [7:0]           csr_write_data,
   input  logic                 advance,
   input  dsfp_pkg::event_type  item,
   output dsfp_pkg::result_type result
);
   import dsfp_pkg::*;

   logic           armed_ff, armed_in;
   logic [31:0]    total_ff, total_in;
   logic [7:0]     one_cnt_ff, one_cnt_in;
   logic [7:0]     two_cnt_ff, two_cnt_in;
   fault_code_type fault_ff, fault_in;
   logic [2:0]     marks_ff, marks_in;
   logic [7:0]     limit_ff;
   logic           alarm;

   always_comb begin
      armed_in   = armed_ff;
      total_in   = total_ff;
      one_cnt_in = one_cnt_ff;
      two_cnt_in = two_cnt_ff;
      fault_in   = fault_ff;
      marks_in   = marks_ff;
      alarm      = 1'b0;
      if (item.pin_low) begin
         unique case (item.command)
            CMD_SENSOR_ONE: begin
               armed_in   = 1'b1;
               one_cnt_in = '0;
               if (fault_ff == FAULT_ONE) begin
                  fault_in = FAULT_NORMAL;
               end
               if (two_cnt_ff != LOSS_COUNT_MAX) begin
                  two_cnt_in = two_cnt_ff + 8'd1;
               end
               if (two_cnt_in > limit_ff) begin
                  fault_in = FAULT_TWO;
                  if (!marks_ff[MARK_TWO]) begin
                     marks_in[MARK_TWO] = 1'b1;
                     alarm              = 1'b1;
                  end
               end
            end
            CMD_SENSOR_TWO: begin
               if (armed_ff) begin
                  total_in = total_ff + 32'd1;
               end
               armed_in   = 1'b0;
               two_cnt_in = '0;
               if (fault_ff == FAULT_TWO) begin
                  fault_in = FAULT_NORMAL;
               end
               if (one_cnt_ff != LOSS_COUNT_MAX) begin
                  one_cnt_in = one_cnt_ff + 8'd1;
               end
               if (one_cnt_in > limit_ff) begin
                  fault_in = FAULT_ONE;
                  if (!marks_ff[MARK_ONE]) begin
                     marks_in[MARK_ONE] = 1'b1;
                     alarm              = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
         // Interference overrides any sensor fault; its absence clears only itself.
         if ((item.interfere_pins & INTERFERE_MASK) == 2'b00) begin
            fault_in = FAULT_IFR;
            if (!marks_ff[MARK_IFR]) begin
               marks_in[MARK_IFR] = 1'b1;
               alarm              = 1'b1;
            end
         end else if (fault_in == FAULT_IFR) begin
            fault_in = FAULT_NORMAL;
         end
      end
      result.flow_count    = total_in;
      result.fault_code    = fault_in;
      result.alarm_request = alarm && !item.uplink_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b0;
         total_ff   <= '0;
         one_cnt_ff <= '0;
         two_cnt_ff <= '0;
         fault_ff   <= FAULT_NORMAL;
         marks_ff   <= '0;
      end else if (advance) begin
         armed_ff   <= armed_in;
         total_ff   <= total_in;
         one_cnt_ff <= one_cnt_in;
         two_cnt_ff <= two_cnt_in;
         fault_ff   <= fault_in;
         marks_ff   <= marks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LOSS_LIMIT_RESET;
      end else if (csr_write_en) begin
         limit_ff <= csr_write_data;
      end
   end

   // The reported marks are sticky: no bit ever falls outside reset.
   a_marks_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (($past(marks_ff) & ~marks_ff) == 3'b000))
      else $error("reported mark cleared outside reset");

   // An alarm is only raised together with a newly set mark.
   a_alarm_sets_mark: assert property (@(posedge clock) disable iff (reset)
      (advance && result.alarm_request) |=> (marks_ff != $past(marks_ff)))
      else $error("alarm request without a new mark");

   // The flow total moves by at most one per cycle.
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((total_ff == $past(total_ff)) || (total_ff == $past(total_ff) + 32'd1)))
      else $error("flow total jumped");

   // A saturated loss counter stays saturated while the other sensor keeps firing.
   a_one_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      (advance && item.pin_low && item.command == CMD_SENSOR_TWO
       && one_cnt_ff == LOSS_COUNT_MAX) |=> (one_cnt_ff == LOSS_COUNT_MAX))
      else $error("sensor one loss counter wrapped");

endmodule

// File: design/dsfp_out_reg.sv
// Result register of the dual-sensor flow pulse counter.
// Holds one result item until the receiving side takes it.
// Depends on dsfp_pkg.
module dsfp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  dsfp_pkg::result_type load_item,
   output logic                 can_load,
   output logic                 out_valid,
   input  logic                 out_stall,
   output dsfp_pkg::result_type out_item
);
   import dsfp_pkg::*;

   logic       valid_ff, valid_in;
   result_type item_ff, item_in;

   assign can_load = !valid_ff || !out_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = load_item;
      end else if (!out_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: design/dual_sensor_flow_pulse_counter.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   command, pin_low, interfere_pins, uplink_busy
// rsp       out        rsp_valid/rsp_stall   flow_count, fault_code, alarm_request
// csr       in         csr_write_en          csr_write_data (loss limit)
//
// One item per cycle is sustained while rsp is not stalled. A taken item waits in the input register
// while the update logic works out its result, which is loaded into the result register once that
// register can take it.
// Synchronous reset clears the counters, fault code and marks and sets the loss limit to 10.
// A stall on rsp holds the result register and, once the input register is full, raises
// req_stall in the same cycle.
// Top level: input register, update logic with state, result register.
// Depends on dsfp_pkg, dsfp_in_reg, dsfp_core and dsfp_out_reg.
module dual_sensor_flow_pulse_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic        req_pin_low,
   input  logic [1:0]  req_interfere_pins,
   input  logic        req_uplink_busy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_flow_count,
   output logic [1:0]  rsp_fault_code,
   output logic        rsp_alarm_request,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data
);
   import dsfp_pkg::*;

   event_type  in_item;
   event_type  held_item;
   logic       held_valid;
   logic       advance;
   logic       can_load;
   result_type next_result;
   result_type rsp_item;

   assign in_item.command        = command_type'(req_command);
   assign in_item.pin_low        = req_pin_low;
   assign in_item.interfere_pins = req_interfere_pins;
   assign in_item.uplink_busy    = req_uplink_busy;

   assign advance = held_valid && can_load;

   dsfp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_item    (in_item),
      .in_stall   (req_stall),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   dsfp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .advance        (advance),
      .item           (held_item),
      .result         (next_result)
   );

   dsfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_item (next_result),
      .can_load  (can_load),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_item)
   );

   assign rsp_flow_count    = rsp_item.flow_count;
   assign rsp_fault_code    = rsp_item.fault_code;
   assign rsp_alarm_request = rsp_item.alarm_request;

endmodule

// File: dv/dual_sensor_flow_pulse_counter_tb.sv
// Self-checking testbench for the dual-sensor flow pulse counter.
// Holds a scoreboard class that predicts flow count, fault code and alarm per item,
// plus the tasks that drive the block; depends only on dsfp_pkg and the block itself.
module dual_sensor_flow_pulse_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dsfp_pkg::*;

   localparam int unsigned SENSOR_ONE_IDX   = 0;
   localparam int unsigned SENSOR_TWO_IDX   = 1;
   localparam int unsigned LONG_HOLD_CYCLES = 80;
   localparam int unsigned TAIL_CYCLES      = 10;
   localparam int unsigned REPORT_LIMIT     = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic        req_pin_low;
   logic [1:0]  req_interfere_pins;
   logic        req_uplink_busy;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_flow_count;
   logic [1:0]  rsp_fault_code;
   logic        rsp_alarm_request;
   logic        csr_write_en;
   logic [7:0]  csr_write_data;

   // Tracks the meter state and holds the readings still owed by the block.
   class flow_result_checker;
      logic [7:0]     loss_limit;
      logic           phase_armed;
      logic [31:0]    forward_total;
      logic [7:0]     missing [2];
      fault_code_type fault;
      logic [2:0]     reported;
      result_type     pending_readings [$];
      int unsigned    errors;
      int unsigned    compared;
      int unsigned    alarms;

      function new();
         loss_limit    = LOSS_LIMIT_RESET;
         phase_armed   = 1'b0;
         forward_total = '0;
         missing[0]    = '0;
         missing[1]    = '0;
         fault         = FAULT_NORMAL;
         reported      = '0;
         errors        = 0;
         compared      = 0;
         alarms        = 0;
      endfunction

      function void set_loss_limit(logic [7:0] value);
         loss_limit = value;
      endfunction

      // One more miss of the given sensor; true on a loss fault seen for the first time.
      function logic count_miss(int unsigned sensor, fault_code_type code, int unsigned mark);
         if (missing[sensor] != LOSS_COUNT_MAX)
            missing[sensor]++;
         if (missing[sensor] > loss_limit) begin
            fault = code;
            if (!reported[mark]) begin
               reported[mark] = 1'b1;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_event(event_type ev);
         result_type want;
         logic       raise;
         raise = 1'b0;
         if (ev.pin_low) begin
            if (ev.command == CMD_SENSOR_ONE) begin
               phase_armed = 1'b1;
               missing[SENSOR_ONE_IDX] = '0;
               if (fault == FAULT_ONE)
                  fault = FAULT_NORMAL;
               raise |= count_miss(SENSOR_TWO_IDX, FAULT_TWO, MARK_TWO);
            end else begin
               if (phase_armed)
                  forward_total++;
               phase_armed = 1'b0;
               missing[SENSOR_TWO_IDX] = '0;
               if (fault == FAULT_TWO)
                  fault = FAULT_NORMAL;
               raise |= count_miss(SENSOR_ONE_IDX, FAULT_ONE, MARK_ONE);
            end
            // Interference is checked last, so it overrides any sensor fault.
            if ((ev.interfere_pins & INTERFERE_MASK) == '0) begin
               fault = FAULT_IFR;
               if (!reported[MARK_IFR]) begin
                  reported[MARK_IFR] = 1'b1;
                  raise = 1'b1;
               end
            end else if (fault == FAULT_IFR) begin
               fault = FAULT_NORMAL;
            end
         end
         want.flow_count    = forward_total;
         want.fault_code    = fault;
         want.alarm_request = raise & ~ev.uplink_busy;
         pending_readings.push_back(want);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_readings.size() == 0) begin
            if (errors < REPORT_LIMIT)
               $display("%0t: unexpected result: flow %0d fault %0d alarm %0b",
                        $realtime, got.flow_count, got.fault_code, got.alarm_request);
            errors++;
            return;
         end
         want = pending_readings.pop_front();
         compared++;
         if (got.alarm_request === 1'b1)
            alarms++;
         if (got.flow_count !== want.flow_count || got.fault_code !== want.fault_code ||
             got.alarm_request !== want.alarm_request) begin
            if (errors < REPORT_LIMIT)
               $display({"%0t: mismatch: expected flow %0d fault %0d alarm %0b, ",
                         "got flow %0d fault %0d alarm %0b"},
                        $realtime, want.flow_count, want.fault_code, want.alarm_request,
                        got.flow_count, got.fault_code, got.alarm_request);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return pending_readings.size();
      endfunction
   endclass

   flow_result_checker meter_board = new();

   bit          sender_idling     = 1'b1;
   bit          receiver_idling   = 1'b1;
   bit          long_hold_request = 1'b0;
   logic [7:0]  loss_setting      = LOSS_LIMIT_RESET;
   int unsigned items_sent        = 0;
   int unsigned limit_settings    = 1;
   int unsigned long_holds        = 0;

   dual_sensor_flow_pulse_counter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_pin_low       (req_pin_low),
      .req_interfere_pins(req_interfere_pins),
      .req_uplink_busy   (req_uplink_busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_flow_count    (rsp_flow_count),
      .rsp_fault_code    (rsp_fault_code),
      .rsp_alarm_request (rsp_alarm_request),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   // The clock starts low so that the first rising edge comes after the initial drives.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic event_type make_event(command_type cmd, logic pin, logic [1:0] pins,
                                            logic busy);
      event_type ev;
      ev.command        = cmd;
      ev.pin_low        = pin;
      ev.interfere_pins = pins;
      ev.uplink_busy    = busy;
      return ev;
   endfunction

   // Valid sensor edge with random interference pins and uplink flag.
   function automatic event_type edge_event(command_type cmd);
      logic [1:0] pins;
      pins = ($urandom_range(0, 99) < 15) ? 2'd0 : 2'($urandom_range(1, 3));
      return make_event(cmd, 1'b1, pins, 1'($urandom_range(0, 1)));
   endfunction

   function automatic int unsigned sender_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Runs of one sensor long enough to trip the loss check where the limit is low.
   function automatic int unsigned run_ceiling();
      return (loss_setting < 16) ? loss_setting + 4 : 12;
   endfunction

   task automatic offer(event_type ev);
      int unsigned gap;
      gap = sender_idling ? sender_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command        <= ev.command;
      req_pin_low        <= ev.pin_low;
      req_interfere_pins <= ev.interfere_pins;
      req_uplink_busy    <= ev.uplink_busy;
      req_valid          <= 1'b1;
      do @(posedge clock); while (req_stall);
      meter_board.note_event(ev);
      items_sent++;
   endtask

   task automatic send_run(command_type cmd, int unsigned count);
      repeat (count) offer(edge_event(cmd));
   endtask

   // The sender stops offering until every reading owed by the block has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (meter_board.pending() != 0);
   endtask

   task automatic write_loss_limit(logic [7:0] value);
      csr_write_data <= value;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      meter_board.set_loss_limit(value);
      loss_setting = value;
      limit_settings++;
   endtask

   task automatic start_phase(logic [7:0] value, bit send_gaps, bit recv_gaps);
      wait_for_results();
      write_loss_limit(value);
      sender_idling   = send_gaps;
      receiver_idling = recv_gaps;
   endtask

   task automatic run_random(int unsigned count);
      int unsigned sent;
      int unsigned roll;
      int unsigned run_len;
      event_type   ev;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            offer(edge_event(CMD_SENSOR_ONE));
            offer(edge_event(CMD_SENSOR_TWO));
            sent += 2;
         end else if (roll < 85) begin
            run_len = $urandom_range(1, run_ceiling());
            send_run(command_type'($urandom_range(0, 1)), run_len);
            sent += run_len;
         end else begin
            ev = make_event(command_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            offer(ev);
            sent += ev.pin_low;
         end
      end
   endtask

   task automatic run_directed();
      // An ignored edge, an edge on an idle phase, one counted pulse and another ignored edge.
      offer(make_event(CMD_SENSOR_ONE, 1'b0, 2'd0, 1'b0));
      offer(make_event(CMD_SENSOR_TWO, 1'b1, 2'd3, 1'b0));
      offer(make_event(CMD_SENSOR_ONE, 1'b1, 2'd1, 1'b0));
      offer(make_event(CMD_SENSOR_TWO, 1'b1, 2'd2, 1'b1));
      offer(make_event(CMD_SENSOR_TWO, 1'b0, 2'd3, 1'b0));
      // Sensor two goes silent past the reset limit while the uplink is busy.
      repeat (11) offer(make_event(CMD_SENSOR_ONE, 1'b1, 2'd3, 1'b1));
      offer(make_event(CMD_SENSOR_ONE, 1'b1, 2'd3, 1'b0));
      // Interference for the first time, then the pins recover.
      offer(make_event(CMD_SENSOR_TWO, 1'b1, 2'd0, 1'b0));
      offer(make_event(CMD_SENSOR_TWO, 1'b1, 2'd2, 1'b0));
      wait_for_results();
      write_loss_limit(8'd0);
      offer(make_event(CMD_SENSOR_TWO, 1'b1, 2'd1, 1'b0));
      // Own clear, other loss and interference all land on the same edge.
      offer(make_event(CMD_SENSOR_ONE, 1'b1, 2'd0, 1'b1));
      // A sensor fault survives the interference pins going high.
      offer(make_event(CMD_SENSOR_ONE, 1'b1, 2'd3, 1'b0));
      offer(make_event(CMD_SENSOR_ONE, 1'b0, 2'd0, 1'b1));
   endtask

   // Receiver: checks accepted results and decides the stall for the next cycle.
   initial begin : result_receiver
      result_type  got;
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.flow_count    = rsp_flow_count;
            got.fault_code    = fault_code_type'(rsp_fault_code);
            got.alarm_request = rsp_alarm_request;
            meter_board.check_result(got);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            long_holds++;
            stall_left = LONG_HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (receiver_idling && $urandom_range(0, 99) < 30) begin
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(7, 29);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_command        <= CMD_SENSOR_ONE;
      req_pin_low        <= 1'b0;
      req_interfere_pins <= 2'd3;
      req_uplink_busy    <= 1'b0;
      csr_write_en       <= 1'b0;
      csr_write_data     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // Highest limit: a long silent run saturates the counter without a loss fault.
      start_phase(8'd255, 1'b1, 1'b1);
      send_run(CMD_SENSOR_ONE, 260);
      run_random(40);

      // Lowest limit, with the receiver holding off long enough to back up the input.
      start_phase(8'd0, 1'b0, 1'b1);
      long_hold_request = 1'b1;
      run_random(150);

      // One below the top of the 8-bit limit range, streamed with no idling on either side.
      start_phase(8'd254, 1'b0, 1'b0);
      send_run(CMD_SENSOR_TWO, 258);
      run_random(20);

      start_phase(LOSS_LIMIT_RESET, 1'b1, 1'b1);
      run_random(100);

      start_phase(8'($urandom_range(1, 20)), 1'b1, 1'b1);
      run_random(100);

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d items over %0d loss-limit settings, %0d long receiver hold(s).",
               items_sent, limit_settings, long_holds);
      $display("Compared %0d results, %0d alarm requests, final flow count %0d.",
               meter_board.compared, meter_board.alarms, meter_board.forward_total);
      if (meter_board.errors == 0 && meter_board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d failure(s), %0d result(s) outstanding", meter_board.errors,
                  meter_board.pending());
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Timed out with %0d result(s) outstanding", meter_board.pending());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
